[rtl/cata_pkg.sv]
// Shared constants, codes and helpers for the client authentication table.
`timescale 1ns / 1ps
`default_nettype none
package cata_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int KEY_W       = 32;
   localparam int TIME_W      = 32;
   localparam int SLOT_W      = 5;
   localparam int ACTION_W    = 2;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd3600;

   localparam logic FUNC_RECORD = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REFRESH = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_APPEND  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_REPLACE = 2'd3;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // Table index reported modulo the slot field range.
   function automatic logic [SLOT_W-1:0] slot_of(input idx_type idx);
      logic [SLOT_W+IDX_W-1:0] ext;
      ext = (SLOT_W + IDX_W)'(idx);
      return ext[SLOT_W-1:0];
   endfunction

endpackage
`default_nettype wire

[rtl/client_auth_table_oldest_replace.sv]
// Top level: client address table with refresh, append, oldest replacement and timed query.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_func, req_client_ip, req_now_sec
//   rsp      out        rsp_valid/stall    rsp_authenticated, rsp_action, rsp_slot
//   csr      in         csr_valid/ready    csr_timeout_sec
//
// An item is accepted, then scanned: one read per stored entry, each checked
// as it returns from the address and time memories; a last step decides and
// writes back.
// Reset clears the entry count, the control state and sets the timeout to 3600.
// A new request is taken only while no item is in progress; a stalled response
// holds the decide step, and a request may be taken while a response waits.
`timescale 1ns / 1ps
`default_nettype none
module client_auth_table_oldest_replace (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [31:0] req_client_ip,
   input  wire logic [31:0] req_now_sec,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_authenticated,
   output logic [1:0]       rsp_action,
   output logic [4:0]       rsp_slot,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_timeout_sec
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [cata_pkg::TIME_W-1:0] timeout_ff;
   cata_pkg::cnt_type used_ff, used_in;
   cata_pkg::cnt_type cnt_ff, cnt_in;
   logic pend_ff, pend_in;
   cata_pkg::idx_type chk_idx_ff, chk_idx_in;
   logic hit_ff, hit_in;
   cata_pkg::idx_type hit_idx_ff, hit_idx_in;
   logic [cata_pkg::TIME_W-1:0] hit_time_ff, hit_time_in;
   cata_pkg::idx_type min_idx_ff, min_idx_in;
   logic [cata_pkg::TIME_W-1:0] min_time_ff, min_time_in;
   logic func_ff, func_in;
   logic [cata_pkg::KEY_W-1:0] key_ff, key_in;
   logic [cata_pkg::TIME_W-1:0] now_ff, now_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic auth_ff, auth_in;
   logic [cata_pkg::ACTION_W-1:0] action_ff, action_in;
   logic [cata_pkg::SLOT_W-1:0] slot_ff, slot_in;

   logic req_take;
   logic rd_en;
   logic [cata_pkg::KEY_W-1:0] rd_key;
   logic [cata_pkg::TIME_W-1:0] rd_time;
   logic addr_we, time_we;
   cata_pkg::idx_type wr_idx;
   logic fin_go;
   logic [cata_pkg::TIME_W-1:0] age;
   logic fresh;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rd_en     = (state_ff == ST_SCAN) && (cnt_ff < used_ff);
   assign fin_go    = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   // Age is read as signed: a stored time in the future counts as fresh.
   assign age   = now_ff - hit_time_ff;
   assign fresh = age[cata_pkg::TIME_W-1]
                  || ({1'b0, age[cata_pkg::TIME_W-2:0]} < timeout_ff);

   cata_ram #(.WIDTH(cata_pkg::KEY_W), .DEPTH(cata_pkg::TABLE_DEPTH)) u_addr_ram (
      .clock   (clock),
      .wr_en   (addr_we),
      .wr_addr (wr_idx),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[cata_pkg::IDX_W-1:0]),
      .rd_data (rd_key)
   );

   cata_ram #(.WIDTH(cata_pkg::TIME_W), .DEPTH(cata_pkg::TABLE_DEPTH)) u_time_ram (
      .clock   (clock),
      .wr_en   (time_we),
      .wr_addr (wr_idx),
      .wr_data (now_ff),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[cata_pkg::IDX_W-1:0]),
      .rd_data (rd_time)
   );

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_time_in  = hit_time_ff;
      min_idx_in   = min_idx_ff;
      min_time_in  = min_time_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      auth_in      = auth_ff;
      action_in    = action_ff;
      slot_in      = slot_ff;
      addr_we      = 1'b0;
      time_we      = 1'b0;
      wr_idx       = hit_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               func_in  = req_func;
               key_in   = req_client_ip;
               now_in   = req_now_sec;
               cnt_in   = '0;
               hit_in   = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               cnt_in     = cnt_ff + 1'b1;
               pend_in    = 1'b1;
               chk_idx_in = cnt_ff[cata_pkg::IDX_W-1:0];
            end
            // Check the entry whose read returned this cycle.
            if (pend_ff) begin
               if (!hit_ff && (rd_key == key_ff)) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = chk_idx_ff;
                  hit_time_in = rd_time;
               end
               if ((chk_idx_ff == '0) || (rd_time < min_time_ff)) begin
                  min_idx_in  = chk_idx_ff;
                  min_time_in = rd_time;
               end
            end
            if (!rd_en) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (fin_go) begin
               rsp_valid_in = 1'b1;
               auth_in      = 1'b0;
               state_in     = ST_IDLE;
               if (func_ff == cata_pkg::FUNC_QUERY) begin
                  auth_in   = hit_ff && fresh;
                  action_in = cata_pkg::ACT_NONE;
                  slot_in   = hit_ff ? cata_pkg::slot_of(hit_idx_ff) : '0;
               end else if (hit_ff) begin
                  time_we   = 1'b1;
                  wr_idx    = hit_idx_ff;
                  action_in = cata_pkg::ACT_REFRESH;
                  slot_in   = cata_pkg::slot_of(hit_idx_ff);
               end else if (used_ff != cata_pkg::CNT_W'(cata_pkg::TABLE_DEPTH)) begin
                  addr_we   = 1'b1;
                  time_we   = 1'b1;
                  wr_idx    = used_ff[cata_pkg::IDX_W-1:0];
                  used_in   = used_ff + 1'b1;
                  action_in = cata_pkg::ACT_APPEND;
                  slot_in   = cata_pkg::slot_of(used_ff[cata_pkg::IDX_W-1:0]);
               end else begin
                  addr_we   = 1'b1;
                  time_we   = 1'b1;
                  wr_idx    = min_idx_ff;
                  action_in = cata_pkg::ACT_REPLACE;
                  slot_in   = cata_pkg::slot_of(min_idx_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= cata_pkg::TIMEOUT_RESET;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_timeout_sec;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      chk_idx_ff  <= chk_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_time_ff <= hit_time_in;
      min_idx_ff  <= min_idx_in;
      min_time_ff <= min_time_in;
      func_ff     <= func_in;
      key_ff      <= key_in;
      now_ff      <= now_in;
      auth_ff     <= auth_in;
      action_ff   <= action_in;
      slot_ff     <= slot_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_authenticated = auth_ff;
   assign rsp_action        = action_ff;
   assign rsp_slot          = slot_ff;

`ifndef SYNTHESIS
   a_take_scan: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a scan");

   a_fin_rsp: assert property (@(posedge clock) disable iff (reset)
      fin_go |=> (rsp_valid && (state_ff == ST_IDLE)))
      else $error("decide step did not present a response");

   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      hit_ff && (state_ff == ST_FIN) |-> ({1'b0, hit_idx_ff} < used_ff))
      else $error("match index beyond used entries");

   a_used_grow: assert property (@(posedge clock) disable iff (reset)
      (used_ff != $past(used_ff)) && !$past(reset)
         |-> (used_ff == $past(used_ff) + 1'b1) && (rsp_action == cata_pkg::ACT_APPEND))
      else $error("entry count changed without an append");
`endif

endmodule
`default_nettype wire

[rtl/cata_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cata_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire
